// ===== design/ilie_pkg.sv =====
// Package for the indexed list block: sizes, command and status codes,
// cell control types shared by the cell row, the top level and the checker.
// No dependencies.
package ilie_pkg;

	localparam int DEPTH = 64;
	localparam int VAL_W = 32;
	localparam int POS_W = 7;
	localparam int CMD_W = 3;
	localparam int ST_W  = 2;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int GRP   = 8;
	localparam int NGRP  = (DEPTH + GRP - 1) / GRP;

	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

	localparam logic [POS_W-1:0] DEPTH_LOW = POS_W'(DEPTH);

	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_PUSH   = 3'd1,
		OP_INSERT = 3'd2,
		OP_ERASE  = 3'd3,
		OP_WRITE  = 3'd4
	} cell_op_t;

	// broadcast to every cell
	typedef struct packed {
		cell_op_t               op;
		logic [CMP_W-1:0]       pos;
		logic [CMP_W-1:0]       cnt;
		logic signed [VAL_W-1:0] val;
	} cell_ctl_t;

endpackage

// ===== design/ilie_cell.sv =====
// One storage cell of the list: holds one element, loads the new value,
// takes its lower or upper neighbor on insert and erase shifts.
// Depends on ilie_pkg.
module ilie_cell import ilie_pkg::*; (
	input  logic                    clk,
	input  cell_ctl_t               ctl,
	input  logic [CMP_W-1:0]        idx,
	input  logic signed [VAL_W-1:0] lo_data,
	input  logic signed [VAL_W-1:0] hi_data,
	output logic signed [VAL_W-1:0] data,
	output logic signed [VAL_W-1:0] rd_data
);

	logic signed [VAL_W-1:0] data_q;
	logic signed [VAL_W-1:0] data_nxt;

	always_comb begin
		data_nxt = data_q;
		case (ctl.op)
			OP_PUSH: begin
				if (idx == ctl.cnt) data_nxt = ctl.val;
			end
			OP_INSERT: begin
				if (idx == ctl.pos) data_nxt = ctl.val;
				else if (idx > ctl.pos) data_nxt = lo_data;
			end
			OP_ERASE: begin
				if (idx >= ctl.pos) data_nxt = hi_data;
			end
			OP_WRITE: begin
				if (idx == ctl.pos) data_nxt = ctl.val;
			end
			default: begin
				data_nxt = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data    = data_q;
	assign rd_data = (idx == ctl.pos) ? data_q : '0;

endmodule

// ===== design/indexed_list_insert_erase.sv =====
// Top level of the indexed list: command decode, element count, row of
// storage cells and a two-level registered read tree. Depends on ilie_pkg, ilie_cell.
//
//   channel | signals                                 | handshake
//   --------+-----------------------------------------+----------------------
//   in      | command, position, element_value        | in_valid / in_ready
//   out     | read_value, count_after, status, is_empty| out_valid / out_ready
//
// Cells and count update at the accept edge; the group OR stage loads there too, and
// the output register loads from it when the output is free or being taken.
// in_ready drops while the group stage holds an item; the next waits until it advances.
// An output stall holds the result; one more item may be accepted meanwhile.
// Reset clears the count and the valid flags; cell contents are not cleared.
module indexed_list_insert_erase import ilie_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CMD_W-1:0]        command,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] element_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] read_value,
	output logic [POS_W-1:0]        count_after,
	output logic [ST_W-1:0]         status,
	output logic                    is_empty
);

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_nxt;
	logic [ST_W-1:0]  st_nxt;
	logic             rd_ok_nxt;
	cell_op_t         op_nxt;
	cell_ctl_t        ctl;
	logic             accept;
	logic             adv;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic             full;
	logic             in_rng;

	logic                    valid_s1;
	logic                    rd_ok_s1;
	logic [ST_W-1:0]         st_s1;
	logic [CNT_W-1:0]        cnt_s1;
	logic signed [VAL_W-1:0] grp_s1 [NGRP];
	logic signed [VAL_W-1:0] grp_or;

	logic signed [VAL_W-1:0] cell_data [DEPTH];
	logic signed [VAL_W-1:0] cell_rd [NGRP*GRP];

	assign in_ready = !valid_s1;
	assign accept   = in_valid && in_ready;
	assign adv      = valid_s1 && (!out_valid || out_ready);

	assign pos_x  = CMP_W'(position);
	assign cnt_x  = CMP_W'(cnt_q);
	assign full   = cnt_x >= CMP_W'(DEPTH);
	assign in_rng = pos_x < cnt_x;

	always_comb begin
		cnt_nxt   = cnt_q;
		st_nxt    = ST_OK;
		rd_ok_nxt = 1'b0;
		op_nxt    = OP_NONE;
		case (command)
			CMD_PUSH: begin
				if (full) st_nxt = ST_FULL;
				else begin
					op_nxt  = OP_PUSH;
					cnt_nxt = CNT_W'(cnt_q + 1'b1);
				end
			end
			CMD_POP: begin
				if (cnt_q == '0) st_nxt = ST_EMPTY;
				else cnt_nxt = CNT_W'(cnt_q - 1'b1);
			end
			CMD_INSERT: begin
				if (pos_x > cnt_x) st_nxt = ST_RANGE;
				else if (full) st_nxt = ST_FULL;
				else begin
					op_nxt  = OP_INSERT;
					cnt_nxt = CNT_W'(cnt_q + 1'b1);
				end
			end
			CMD_ERASE: begin
				if (!in_rng) st_nxt = ST_RANGE;
				else begin
					op_nxt  = OP_ERASE;
					cnt_nxt = CNT_W'(cnt_q - 1'b1);
				end
			end
			CMD_READ: begin
				if (!in_rng) st_nxt = ST_RANGE;
				else rd_ok_nxt = 1'b1;
			end
			CMD_WRITE: begin
				if (!in_rng) st_nxt = ST_RANGE;
				else op_nxt = OP_WRITE;
			end
			CMD_CLEAR: begin
				cnt_nxt = '0;
			end
			default: begin
				cnt_nxt = cnt_q;
			end
		endcase
	end

	always_comb begin
		ctl.op  = accept ? op_nxt : OP_NONE;
		ctl.pos = pos_x;
		ctl.cnt = cnt_x;
		ctl.val = element_value;
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [VAL_W-1:0] lo;
		logic signed [VAL_W-1:0] hi;
		if (g == 0) begin : g_lo0
			assign lo = '0;
		end else begin : g_lo
			assign lo = cell_data[g-1];
		end
		if (g == DEPTH - 1) begin : g_hin
			assign hi = '0;
		end else begin : g_hi
			assign hi = cell_data[g+1];
		end
		ilie_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.idx     (CMP_W'(g)),
			.lo_data (lo),
			.hi_data (hi),
			.data    (cell_data[g]),
			.rd_data (cell_rd[g])
		);
	end

	for (genvar p = DEPTH; p < NGRP*GRP; p++) begin : g_pad
		assign cell_rd[p] = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) cnt_q <= cnt_nxt;
			if (accept) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_s1 <= rd_ok_nxt;
			st_s1    <= st_nxt;
			cnt_s1   <= cnt_nxt;
			for (int g = 0; g < NGRP; g++) begin
				logic signed [VAL_W-1:0] acc;
				acc = '0;
				for (int k = 0; k < GRP; k++) acc = acc | cell_rd[g*GRP + k];
				grp_s1[g] <= acc;
			end
		end
	end

	always_comb begin
		grp_or = '0;
		for (int g = 0; g < NGRP; g++) grp_or = grp_or | grp_s1[g];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			if (adv) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_value  <= rd_ok_s1 ? grp_or : '0;
			count_after <= POS_W'(cnt_s1);
			status      <= st_s1;
			is_empty    <= (cnt_s1 == '0);
		end
	end

endmodule

// ===== design/ilie_checker.sv =====
// Port-level checks on the indexed list results, bound to the top level.
// Depends on ilie_pkg and indexed_list_insert_erase.
module ilie_checker import ilie_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [VAL_W-1:0] read_value,
	input logic [POS_W-1:0]        count_after,
	input logic [ST_W-1:0]         status,
	input logic                    is_empty
);

	a_empty_st: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> is_empty && count_after == '0)
		else $error("empty status with nonzero count");

	a_rd_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_value != '0 |-> status == ST_OK)
		else $error("read value on failed command");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> count_after == DEPTH_LOW && !is_empty)
		else $error("full status with count below depth");

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> ##1 out_valid)
		else $error("result missing two cycles after item");

endmodule

bind indexed_list_insert_erase ilie_checker u_ilie_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.read_value  (read_value),
	.count_after (count_after),
	.status      (status),
	.is_empty    (is_empty)
);

// ===== tb/sv/ilie_list_checker.sv =====
`timescale 1ns / 1ps
// Checker for the indexed list: follows accepted commands, keeps its own copy of
// the list and compares every accepted result with the oldest outstanding one.
// Depends on ilie_pkg.
module ilie_list_checker import ilie_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [CMD_W-1:0]        command,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] element_value,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic signed [VAL_W-1:0] read_value,
	input  logic [POS_W-1:0]        count_after,
	input  logic [ST_W-1:0]         status,
	input  logic                    is_empty,
	output int                      mismatches,
	output int                      pending,
	output int                      list_len
);

	typedef struct {
		logic signed [VAL_W-1:0] rd_value;
		logic [POS_W-1:0]        count;
		logic [ST_W-1:0]         status;
		logic                    empty_flag;
	} list_result_t;

	list_result_t            expected_q[$];
	logic signed [VAL_W-1:0] cells [DEPTH];
	int                      held;
	int                      fails;

	function automatic list_result_t apply_list_command(input logic [CMD_W-1:0] cmd,
			input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] val);
		list_result_t res;
		int p;
		int i;
		p = int'(pos);
		res.rd_value = '0;
		res.status = ST_OK;
		case (cmd)
			CMD_PUSH: begin
				if (held >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					cells[held] = val;
					held++;
				end
			end
			CMD_POP: begin
				if (held == 0) res.status = ST_EMPTY;
				else held--;
			end
			CMD_INSERT: begin
				if (p > held) begin
					res.status = ST_RANGE;
				end else if (held >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (i = held; i > p; i--) cells[i] = cells[i-1];
					cells[p] = val;
					held++;
				end
			end
			CMD_ERASE: begin
				if (p >= held) begin
					res.status = ST_RANGE;
				end else begin
					for (i = p; i + 1 < held; i++) cells[i] = cells[i+1];
					held--;
				end
			end
			CMD_READ: begin
				if (p >= held) res.status = ST_RANGE;
				else res.rd_value = cells[p];
			end
			CMD_WRITE: begin
				if (p >= held) res.status = ST_RANGE;
				else cells[p] = val;
			end
			CMD_CLEAR: held = 0;
			default: ;
		endcase
		res.count = POS_W'(held);
		res.empty_flag = (held == 0);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		list_result_t want;
		if (!arst_n) begin
			held = 0;
			fails = 0;
			expected_q.delete();
			pending <= 0;
			list_len <= 0;
			mismatches <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected result: expected none, %s %0d %0d %0d %0d",
						$time, "actual value/count/status/empty",
						read_value, count_after, status, is_empty);
				end else begin
					want = expected_q.pop_front();
					if (read_value !== want.rd_value) begin
						fails++;
						$display("%0t: read_value expected %0d actual %0d",
							$time, want.rd_value, read_value);
					end
					if (count_after !== want.count) begin
						fails++;
						$display("%0t: count_after expected %0d actual %0d",
							$time, want.count, count_after);
					end
					if (status !== want.status) begin
						fails++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
					end
					if (is_empty !== want.empty_flag) begin
						fails++;
						$display("%0t: is_empty expected %0d actual %0d",
							$time, want.empty_flag, is_empty);
					end
				end
			end
			if (in_valid && in_ready)
				expected_q = {expected_q,
					apply_list_command(command, position, element_value)};
			pending <= expected_q.size();
			list_len <= held;
			mismatches <= fails;
		end
	end

endmodule

// ===== tb/sv/indexed_list_insert_erase_tb.sv =====
`timescale 1ns / 1ps
// Top of the indexed list testbench: clock, reset, command stimulus and output
// stalls; results are checked by ilie_list_checker. Depends on ilie_pkg, indexed_list_insert_erase.
module indexed_list_insert_erase_tb;
	import ilie_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam int RANDOM_ITEMS = 1000;
	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_LEN     = 250;

	typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIX} load_phase_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic [CMD_W-1:0]        command = '0;
	logic [POS_W-1:0]        position = '0;
	logic signed [VAL_W-1:0] element_value = '0;
	logic                    out_ready = 1'b0;
	logic                    in_ready;
	logic                    out_valid;
	logic signed [VAL_W-1:0] read_value;
	logic [POS_W-1:0]        count_after;
	logic [ST_W-1:0]         status;
	logic                    is_empty;

	int mismatches;
	int pending;
	int list_len;
	int items_sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int rx_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	int rx_tick = 0;
	bit hold_done = 1'b0;

	indexed_list_insert_erase DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .position(position), .element_value(element_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_value(read_value), .count_after(count_after),
		.status(status), .is_empty(is_empty)
	);

	ilie_list_checker list_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .position(position), .element_value(element_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_value(read_value), .count_after(count_after),
		.status(status), .is_empty(is_empty),
		.mismatches(mismatches), .pending(pending), .list_len(list_len)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] val);
		in_valid <= 1'b1;
		command <= cmd;
		position <= pos;
		element_value <= val;
		do @(posedge clk); while (!in_ready);
		items_sent <= items_sent + 1;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 40);
		end
	endtask

	initial begin
		int n;
		int phase_left;
		int r;
		int len;
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] pos;
		logic signed [VAL_W-1:0] val;
		load_phase_t phase;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corner cases
		send_item(CMD_POP,    7'd0, 32'sd0);
		send_item(CMD_READ,   7'd0, 32'sd0);
		send_item(CMD_ERASE,  7'd0, 32'sd0);
		send_item(CMD_WRITE,  7'd0, 32'sd5);
		send_item(CMD_INSERT, 7'd1, 32'sd9);
		// build [min, max, 0, -1]; insert in the middle, at the end and past it
		send_item(CMD_INSERT, 7'd0, 32'h8000_0000);
		send_item(CMD_PUSH,   7'd0, 32'h7FFF_FFFF);
		send_item(CMD_PUSH,   7'd0, 32'h0000_0000);
		send_item(CMD_PUSH,   7'd0, 32'hFFFF_FFFF);
		send_item(CMD_INSERT, 7'd2, 32'h5555_5555);
		send_item(CMD_INSERT, 7'd5, 32'hAAAA_AAAA);
		send_item(CMD_INSERT, 7'd7, 32'sd1);
		send_item(CMD_READ,   7'd0, 32'sd0);
		send_item(CMD_READ,   7'd5, 32'sd0);
		send_item(CMD_READ,   7'd6, 32'sd0);
		send_item(CMD_WRITE,  7'd1, 32'h1234_5678);
		send_item(CMD_ERASE,  7'd0, 32'sd0);
		send_item(CMD_ERASE,  7'd4, 32'sd0);
		send_item(CMD_READ,   7'd127, 32'sd0);
		send_item(CMD_ERASE,  7'd64, 32'sd0);
		send_item(CMD_UNUSED, 7'd127, 32'hDEAD_BEEF);
		send_item(CMD_READ,   7'd1, 32'sd0);
		send_item(CMD_CLEAR,  7'd0, 32'sd0);
		send_item(CMD_POP,    7'd0, 32'sd0);
		send_item(CMD_READ,   7'd0, 32'sd0);

		// random part: phases that fill the list to full, drain it, or mix
		phase = PH_FILL;
		phase_left = $urandom_range(100, 150);
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				phase = load_phase_t'($urandom_range(0, 2));
				phase_left = $urandom_range(30, 150);
			end
			phase_left--;

			r = $urandom_range(0, 99);
			case (phase)
				PH_FILL: begin
					if (r < 45) cmd = CMD_PUSH;
					else if (r < 80) cmd = CMD_INSERT;
					else if (r < 88) cmd = CMD_READ;
					else if (r < 95) cmd = CMD_WRITE;
					else if (r < 98) cmd = CMD_ERASE;
					else cmd = CMD_POP;
				end
				PH_DRAIN: begin
					if (r < 30) cmd = CMD_POP;
					else if (r < 65) cmd = CMD_ERASE;
					else if (r < 80) cmd = CMD_READ;
					else if (r < 90) cmd = CMD_WRITE;
					else if (r < 95) cmd = CMD_PUSH;
					else cmd = CMD_INSERT;
				end
				default: begin
					if (r < 14) cmd = CMD_PUSH;
					else if (r < 28) cmd = CMD_POP;
					else if (r < 42) cmd = CMD_INSERT;
					else if (r < 56) cmd = CMD_ERASE;
					else if (r < 76) cmd = CMD_READ;
					else if (r < 94) cmd = CMD_WRITE;
					else if (r < 97) cmd = CMD_CLEAR;
					else cmd = CMD_UNUSED;
				end
			endcase

			// list_len may lag by the item in flight; close enough for aiming
			len = list_len;
			r = $urandom_range(0, 99);
			if (r < 60) pos = POS_W'($urandom_range(0, (len > 0) ? len - 1 : 0));
			else if (r < 80) pos = POS_W'(len);
			else pos = POS_W'($urandom_range(0, 127));

			r = $urandom_range(0, 99);
			case (r)
				0, 1: val = 32'h8000_0000;
				2, 3: val = 32'h7FFF_FFFF;
				4, 5: val = 32'h0000_0000;
				6, 7: val = 32'hFFFF_FFFF;
				default: val = $urandom;
			endcase

			send_item(cmd, pos, val);
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// output stalls: random modes, plus one long hold-off while items keep coming
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && items_sent >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(10, 80);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1);
				2: out_ready <= (rx_tick % 4 == 0);
				default: out_ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

endmodule
